// ===== hdl/wrcp_pkg.sv =====
// ---------------------------------------------------------------------------
// wrcp_pkg
// Shared types and constants for the RIFF/WAVE chunk parser.
// ---------------------------------------------------------------------------
package wrcp_pkg;

    typedef enum logic [4:0] {
        PH_FILE = 5'b00001,
        PH_CHDR = 5'b00010,
        PH_BODY = 5'b00100,
        PH_PAD  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    localparam logic [1:0] KIND_FMT    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_TAG_PCM   = 16'h0001;
    localparam logic [31:0] DEFAULT_RATE  = 32'd22050;
    localparam logic [15:0] DEFAULT_CHAN  = 16'd1;
    localparam logic [15:0] DEFAULT_BITS  = 16'd16;

    localparam int FILE_HDR_BYTES  = 12;
    localparam int CHUNK_HDR_BYTES = 8;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [1:0]  format_code;
        logic [31:0] sample_rate;
        logic [31:0] data_size;
        logic [15:0] sample_value;
        logic        end_of_file;
    } t_result;

endpackage

// ===== hdl/wrcp_core.sv =====
// ---------------------------------------------------------------------------
// wrcp_core
// Parser state and per-byte update; produces at most one result per byte.
// ---------------------------------------------------------------------------
module wrcp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_sof,
    output wrcp_pkg::t_result o_result
);
    import wrcp_pkg::*;

    t_phase             r_phase, c_phase, n_phase;
    logic [3:0]         r_idx, c_idx, n_idx;
    logic signed [32:0] r_remain, c_remain, n_remain;
    logic [31:0]        r_tag, c_tag, n_tag;
    logic [31:0]        r_len, c_len, n_len;
    logic [31:0]        r_pos, c_pos, n_pos;
    logic [15:0]        r_ftag, c_ftag, n_ftag;
    logic [15:0]        r_chan, c_chan, n_chan;
    logic [15:0]        r_bits, c_bits, n_bits;
    logic [31:0]        r_rate, c_rate, n_rate;
    logic [7:0]         r_low, c_low, n_low;

    logic               chunk_done;
    logic               has_kind;
    logic               eof;
    logic [1:0]         kind;
    logic [31:0]        dsize;
    logic [15:0]        sval;
    logic signed [33:0] init_t;
    logic signed [33:0] init_rem;
    logic [33:0]        span;
    logic signed [34:0] done_rem;

    always_comb begin
        // start of file behaves as a reset just ahead of this byte
        if (i_sof) begin
            c_phase  = PH_FILE;
            c_idx    = '0;
            c_remain = '0;
            c_tag    = '0;
            c_len    = '0;
            c_pos    = '0;
            c_ftag   = '0;
            c_chan   = DEFAULT_CHAN;
            c_bits   = DEFAULT_BITS;
            c_rate   = DEFAULT_RATE;
            c_low    = '0;
        end else begin
            c_phase  = r_phase;
            c_idx    = r_idx;
            c_remain = r_remain;
            c_tag    = r_tag;
            c_len    = r_len;
            c_pos    = r_pos;
            c_ftag   = r_ftag;
            c_chan   = r_chan;
            c_bits   = r_bits;
            c_rate   = r_rate;
            c_low    = r_low;
        end
    end

    always_comb begin
        n_phase    = c_phase;
        n_idx      = c_idx;
        n_remain   = c_remain;
        n_tag      = c_tag;
        n_len      = c_len;
        n_pos      = c_pos;
        n_ftag     = c_ftag;
        n_chan     = c_chan;
        n_bits     = c_bits;
        n_rate     = c_rate;
        n_low      = c_low;
        chunk_done = 1'b0;
        has_kind   = 1'b0;
        eof        = 1'b0;
        kind       = KIND_END;
        dsize      = '0;
        sval       = '0;

        // riff size rounded up to even, less the wave id
        init_t      = {{2{c_len[31]}}, c_len} + 34'sd1;
        init_t[0]   = 1'b0;
        init_rem    = init_t - 34'sd4;

        unique case (c_phase)
            PH_FILE: begin
                if (c_idx[3:2] == 2'b01) begin
                    n_len[{c_idx[1:0], 3'b000} +: 8] = i_byte;
                end
                n_idx = c_idx + 4'd1;
                if (n_idx >= 4'(FILE_HDR_BYTES)) begin
                    n_remain = init_rem[32:0];
                    n_idx    = '0;
                    n_len    = '0;
                    if (init_rem[33] || init_rem == '0) begin
                        n_phase = PH_DONE;
                        eof     = 1'b1;
                    end else begin
                        n_phase = PH_CHDR;
                    end
                end
            end
            PH_CHDR: begin
                if (c_idx == '0) begin
                    n_len = '0;
                end
                if (c_idx[3:2] == 2'b00) begin
                    n_tag = {c_tag[23:0], i_byte};
                end else if (c_idx[3:2] == 2'b01) begin
                    n_len[{c_idx[1:0], 3'b000} +: 8] = i_byte;
                end
                n_idx = c_idx + 4'd1;
                if (n_idx >= 4'(CHUNK_HDR_BYTES)) begin
                    n_idx = '0;
                    n_pos = '0;
                    if (n_tag == TAG_DATA && c_ftag == FMT_TAG_PCM) begin
                        has_kind = 1'b1;
                        kind     = KIND_DATA;
                        dsize    = n_len;
                    end
                    if (n_len == '0) begin
                        chunk_done = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (c_tag == TAG_FMT) begin
                    if (c_pos[31:4] == '0) begin
                        unique case (c_pos[3:0])
                            4'd0: n_ftag[7:0]  = i_byte;
                            4'd1: n_ftag[15:8] = i_byte;
                            4'd2: n_chan[7:0]  = i_byte;
                            4'd3: n_chan[15:8] = i_byte;
                            4'd4, 4'd5, 4'd6, 4'd7: begin
                                if (c_ftag == FMT_TAG_PCM) begin
                                    n_rate[{c_pos[1:0], 3'b000} +: 8] = i_byte;
                                end
                            end
                            4'd14: n_bits[7:0] = i_byte;
                            4'd15: begin
                                n_bits[15:8] = i_byte;
                                if (c_ftag == FMT_TAG_PCM) begin
                                    has_kind = 1'b1;
                                    kind     = KIND_FMT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (c_tag == TAG_DATA && c_ftag == FMT_TAG_PCM) begin
                    if (c_bits == 16'd16) begin
                        if (c_pos[0]) begin
                            has_kind = 1'b1;
                            kind     = KIND_SAMPLE;
                            sval     = {i_byte, c_low};
                        end else begin
                            n_low = i_byte;
                            // odd trailing byte goes out alone
                            if (c_pos + 32'd1 == c_len) begin
                                has_kind = 1'b1;
                                kind     = KIND_SAMPLE;
                                sval     = {8'd0, i_byte};
                            end
                        end
                    end else begin
                        has_kind = 1'b1;
                        kind     = KIND_SAMPLE;
                        sval     = {8'd0, i_byte};
                    end
                end
                n_pos = c_pos + 32'd1;
                if (n_pos == c_len) begin
                    if (c_len[0]) begin
                        n_phase = PH_PAD;
                    end else begin
                        chunk_done = 1'b1;
                    end
                end
            end
            PH_PAD: begin
                chunk_done = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        span     = {1'b0, ({1'b0, n_len} + 33'd1) & ~33'd1} + 34'd8;
        done_rem = {{2{c_remain[32]}}, c_remain} - $signed({1'b0, span});
        if (chunk_done) begin
            n_remain = done_rem[32:0];
            n_idx    = '0;
            if (done_rem[34] || done_rem == '0) begin
                n_phase = PH_DONE;
                eof     = 1'b1;
            end else begin
                n_phase = PH_CHDR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FILE;
            r_idx    <= '0;
            r_remain <= '0;
            r_tag    <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_ftag   <= '0;
            r_chan   <= DEFAULT_CHAN;
            r_bits   <= DEFAULT_BITS;
            r_rate   <= DEFAULT_RATE;
            r_low    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_remain <= n_remain;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_ftag   <= n_ftag;
            r_chan   <= n_chan;
            r_bits   <= n_bits;
            r_rate   <= n_rate;
            r_low    <= n_low;
        end
    end

    always_comb begin
        o_result.valid        = has_kind || eof;
        o_result.kind         = kind;
        o_result.format_code  = {n_chan != 16'd1, n_bits != 16'd8};
        o_result.sample_rate  = n_rate;
        o_result.data_size    = dsize;
        o_result.sample_value = sval;
        o_result.end_of_file  = eof;
    end

endmodule

// ===== hdl/wav_riff_chunk_parser_top.sv =====
// ---------------------------------------------------------------------------
// wav_riff_chunk_parser_top
// Byte-stream RIFF/WAVE parser reporting PCM format, data chunks and samples.
// ---------------------------------------------------------------------------
// One file byte is taken per clock cycle, back to back; each byte is parsed
// in the cycle it is accepted and its result, if any, appears in the output
// register on the next cycle. Throughput is one byte per cycle, set only by
// the output register: while a result waits there and the sink stalls, input
// stops. A byte with tuser set restarts the parser at the file header. After
// the last chunk the parser ignores bytes until the next start of file; the
// result of the byte that ends parsing carries tlast.
module wav_riff_chunk_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // file_byte
    input  logic        s_axis_tuser,   // start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // format_code, sample_rate, data_size,
                                        // sample_value, zero pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // end_of_file
);
    import wrcp_pkg::*;

    logic    in_xfer;
    t_result core_res;
    logic    r_valid;
    t_result r_res;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    wrcp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_byte   (s_axis_tdata),
        .i_sof    (s_axis_tuser),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= core_res.valid;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && core_res.valid) begin
            r_res <= core_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.end_of_file;
    assign m_axis_tdata  = {6'd0, r_res.sample_value, r_res.data_size,
                            r_res.sample_rate, r_res.format_code};

endmodule

// ===== hdl/wrcp_checker.sv =====
// ---------------------------------------------------------------------------
// wrcp_checker
// Port-level checks for the parser output stream.
// ---------------------------------------------------------------------------
module wrcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import wrcp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end-only result without end of file");

    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[65:34] == '0)
        else $error("data size outside data chunk start");

    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_SAMPLE |-> m_axis_tdata[81:66] == '0)
        else $error("sample value outside sample result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind wav_riff_chunk_parser_top wrcp_checker u_wrcp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/wav_riff_chunk_parser_top_tb.sv =====
// ---------------------------------------------------------------------------
// wav_riff_chunk_parser_top_tb
// Streams WAV files byte by byte into the parser and checks every report.
// A byte-level model of the parser predicts each report as the byte
// transfers in. The monitor compares each report with the oldest prediction.
// Directed files come first: empty and negative header counts, data ahead of
// fmt, short and non-PCM fmt, odd data tails, zero-length chunks and restarts.
// Random files and noise follow under four idle and stall mixes.
// ---------------------------------------------------------------------------
module wav_riff_chunk_parser_top_tb;
    import wrcp_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PHASE_BYTES = 325;
    localparam logic [31:0] ID_RIFF     = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE     = 32'h5741_5645;
    localparam logic [31:0] ID_LIST     = 32'h4C49_5354;
    localparam logic [31:0] ID_FMT_BANG = 32'h666D_7421;

    typedef struct {
        logic [7:0] b;
        logic       sof;
    } t_file_byte;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  fmt;
        logic [31:0] rate;
        logic [31:0] size;
        logic [15:0] sample;
        logic        eof;
    } t_wav_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'd0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [87:0] m_data;
    logic [1:0]  m_user;
    logic        m_last;

    t_file_byte  byte_backlog[$];
    t_wav_report expected_reports[$];
    logic [7:0]  file_body[$];
    logic [7:0]  body_fill[$];
    t_file_byte  next_byte;
    t_wav_report oldest_report;
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          err_count = 0;
    int          cycles = 0;

    // parser model state
    t_phase      ph;
    int          hdr_idx;
    longint      bytes_left;
    logic [31:0] cur_id;
    logic [31:0] cur_len;
    logic [31:0] body_pos;
    logic [15:0] wfmt_tag;
    logic [15:0] wchan;
    logic [15:0] wbits;
    logic [31:0] wrate;
    logic [7:0]  held_lo;

    wav_riff_chunk_parser_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // file_byte
        .s_axis_tuser  (s_user),    // start_of_file
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),    // format_code, sample_rate, data_size,
                                    // sample_value, zero pad
        .m_axis_tuser  (m_user),    // kind
        .m_axis_tlast  (m_last)     // end_of_file
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function void reset_parser();
        ph         = PH_FILE;
        hdr_idx    = 0;
        bytes_left = 0;
        cur_id     = '0;
        cur_len    = '0;
        body_pos   = '0;
        wfmt_tag   = '0;
        wchan      = DEFAULT_CHAN;
        wbits      = DEFAULT_BITS;
        wrate      = DEFAULT_RATE;
        held_lo    = '0;
    endfunction

    function automatic logic [1:0] format_of();
        return {wchan != 16'd1, wbits != 16'd8};
    endfunction

    function void parse_byte(input logic [7:0] b, input logic sof);
        logic        has;
        logic        eof;
        logic        done;
        logic [1:0]  kd;
        logic [31:0] dsz;
        logic [15:0] sv;
        longint      hdr_size;
        int          p;
        t_wav_report r;
        has = 1'b0;
        eof = 1'b0;
        done = 1'b0;
        kd = KIND_END;
        dsz = '0;
        sv = '0;
        if (sof) reset_parser();
        case (ph)
            PH_FILE: begin
                if (hdr_idx >= 4 && hdr_idx < 8)
                    cur_len = cur_len | ({24'd0, b} << (8 * (hdr_idx - 4)));
                hdr_idx++;
                if (hdr_idx >= FILE_HDR_BYTES) begin
                    hdr_size = longint'($signed(cur_len));
                    // round size plus one down to even, minus the wave id
                    bytes_left = ((hdr_size + 1) & ~64'sd1) - 4;
                    hdr_idx = 0;
                    cur_len = '0;
                    if (bytes_left <= 0) begin
                        ph = PH_DONE;
                        eof = 1'b1;
                    end else begin
                        ph = PH_CHDR;
                    end
                end
            end
            PH_CHDR: begin
                if (hdr_idx == 0) cur_len = '0;
                if (hdr_idx < 4)
                    cur_id = {cur_id[23:0], b};
                else if (hdr_idx < 8)
                    cur_len = cur_len | ({24'd0, b} << (8 * (hdr_idx - 4)));
                hdr_idx++;
                if (hdr_idx >= CHUNK_HDR_BYTES) begin
                    hdr_idx = 0;
                    body_pos = '0;
                    if (cur_id == TAG_DATA && wfmt_tag == FMT_TAG_PCM) begin
                        has = 1'b1;
                        kd = KIND_DATA;
                        dsz = cur_len;
                    end
                    if (cur_len == 0) done = 1'b1;
                    else ph = PH_BODY;
                end
            end
            PH_BODY: begin
                p = int'(body_pos);
                if (cur_id == TAG_FMT) begin
                    if (p == 0) wfmt_tag[7:0] = b;
                    else if (p == 1) wfmt_tag[15:8] = b;
                    else if (p == 2) wchan[7:0] = b;
                    else if (p == 3) wchan[15:8] = b;
                    else if (p >= 4 && p < 8) begin
                        if (wfmt_tag == FMT_TAG_PCM) wrate[8 * (p - 4) +: 8] = b;
                    end else if (p == 14) wbits[7:0] = b;
                    else if (p == 15) begin
                        wbits[15:8] = b;
                        if (wfmt_tag == FMT_TAG_PCM) begin
                            has = 1'b1;
                            kd = KIND_FMT;
                        end
                    end
                end else if (cur_id == TAG_DATA && wfmt_tag == FMT_TAG_PCM) begin
                    if (wbits == 16'd16) begin
                        if (body_pos[0]) begin
                            has = 1'b1;
                            kd = KIND_SAMPLE;
                            sv = {b, held_lo};
                        end else begin
                            held_lo = b;
                            // lone trailing byte goes out zero-extended
                            if (body_pos + 1 == cur_len) begin
                                has = 1'b1;
                                kd = KIND_SAMPLE;
                                sv = {8'd0, b};
                            end
                        end
                    end else begin
                        has = 1'b1;
                        kd = KIND_SAMPLE;
                        sv = {8'd0, b};
                    end
                end
                body_pos = body_pos + 1;
                if (body_pos == cur_len) begin
                    if (cur_len[0]) ph = PH_PAD;
                    else done = 1'b1;
                end
            end
            PH_PAD: begin
                done = 1'b1;
            end
            default: begin
            end
        endcase
        if (done) begin
            bytes_left = bytes_left - (((longint'(cur_len) + 1) & ~64'sd1) + 8);
            hdr_idx = 0;
            if (bytes_left <= 0) begin
                ph = PH_DONE;
                eof = 1'b1;
            end else begin
                ph = PH_CHDR;
            end
        end
        if (!has && eof) begin
            has = 1'b1;
            kd = KIND_END;
        end
        if (has) begin
            r.kind = kd;
            r.fmt = format_of();
            r.rate = wrate;
            r.size = dsz;
            r.sample = sv;
            r.eof = eof;
            expected_reports.insert(expected_reports.size(), r);
        end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // ---- stimulus building ----

    function void push_byte(logic [7:0] b, logic sof);
        t_file_byte fb;
        fb.b = b;
        fb.sof = sof;
        byte_backlog.insert(byte_backlog.size(), fb);
    endfunction

    function void add_body_byte(logic [7:0] b);
        file_body.insert(file_body.size(), b);
    endfunction

    function void add_fill_byte(logic [7:0] b);
        body_fill.insert(body_fill.size(), b);
    endfunction

    function void body_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) add_body_byte(v[8 * i +: 8]);
    endfunction

    // chunk body takes prepared bytes from body_fill first, then random ones
    function void add_chunk(logic [31:0] id, int len);
        for (int i = 3; i >= 0; i--) add_body_byte(id[8 * i +: 8]);
        body_le(len, 4);
        for (int i = 0; i < len; i++) begin
            if (body_fill.size() != 0) add_body_byte(body_fill.pop_front());
            else add_body_byte(8'($urandom));
        end
        if (len % 2 == 1) add_body_byte(8'($urandom));
        body_fill.delete();
    endfunction

    function void add_fmt(int len, logic [15:0] tag, logic [15:0] chan,
                          logic [31:0] rate, logic [15:0] bits);
        logic [31:0] junk;
        junk = $urandom;
        body_fill.delete();
        for (int i = 0; i < 2; i++) add_fill_byte(tag[8 * i +: 8]);
        for (int i = 0; i < 2; i++) add_fill_byte(chan[8 * i +: 8]);
        for (int i = 0; i < 4; i++) add_fill_byte(rate[8 * i +: 8]);
        for (int i = 0; i < 4; i++) add_fill_byte(junk[8 * i +: 8]);
        for (int i = 0; i < 2; i++) add_fill_byte(8'($urandom));
        for (int i = 0; i < 2; i++) add_fill_byte(bits[8 * i +: 8]);
        add_chunk(TAG_FMT, len);
    endfunction

    function void emit_file(logic [31:0] riff_size);
        for (int i = 3; i >= 0; i--) push_byte(ID_RIFF[8 * i +: 8], i == 3);
        for (int i = 0; i < 4; i++) push_byte(riff_size[8 * i +: 8], 1'b0);
        for (int i = 3; i >= 0; i--) push_byte(ID_WAVE[8 * i +: 8], 1'b0);
        foreach (file_body[i]) push_byte(file_body[i], 1'b0);
        file_body.delete();
    endfunction

    function automatic logic [31:0] junk_id();
        case ($urandom_range(2))
            0: return ID_LIST;
            1: return ID_FMT_BANG;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_16(logic [15:0] a, logic [15:0] b);
        case ($urandom_range(9))
            0: return 16'($urandom);
            1, 2, 3, 4: return a;
            default: return b;
        endcase
    endfunction

    function void random_file();
        int          span;
        int          flen;
        logic [15:0] tag;
        logic [31:0] rate;
        logic [31:0] riff_size;
        if (chance(8)) begin
            // noise, with an occasional restart inside it
            repeat ($urandom_range(5, 30)) push_byte(8'($urandom), chance(5));
            return;
        end
        if (chance(10)) add_chunk(TAG_DATA, $urandom_range(0, 6));
        if (chance(25)) add_chunk(junk_id(), $urandom_range(0, 9));
        if (!chance(8)) begin
            tag = chance(80) ? FMT_TAG_PCM : 16'($urandom);
            rate = chance(10) ? (chance(50) ? 32'd0 : 32'hFFFF_FFFF) : $urandom;
            flen = chance(75) ? 16 : (chance(50) ? 18 : $urandom_range(0, 15));
            add_fmt(flen, tag, pick_16(16'd1, 16'd2), rate, pick_16(16'd8, 16'd16));
        end
        add_chunk(TAG_DATA, $urandom_range(0, 40));
        if (chance(15)) add_chunk(TAG_DATA, $urandom_range(0, 5));
        if (chance(30)) add_chunk(junk_id(), $urandom_range(0, 7));
        span = file_body.size();
        case ($urandom_range(11))
            0: riff_size = $urandom;
            1: riff_size = $urandom_range(0, 8);
            2: riff_size = span + 4 - $urandom_range(1, 20);
            3: riff_size = span + 4 + $urandom_range(1, 3);
            4: riff_size = span + 3;
            default: riff_size = span + 4;
        endcase
        emit_file(riff_size);
        if (chance(30)) repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
    endfunction

    task automatic wait_drained();
        while (byte_backlog.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // ---- driver ----
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) parse_byte(s_data, s_user);
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_byte = byte_backlog.pop_front();
                s_valid <= 1'b1;
                s_data <= next_byte.b;
                s_user <= next_byte.sof;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---- monitor ----
    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected transfer: kind %0d", m_user);
                err_count++;
            end else begin
                oldest_report = expected_reports.pop_front();
                check_field("kind", oldest_report.kind, m_user);
                check_field("format_code", oldest_report.fmt, m_data[1:0]);
                check_field("sample_rate", oldest_report.rate, m_data[33:2]);
                check_field("data_size", oldest_report.size, m_data[65:34]);
                check_field("sample_value", oldest_report.sample, m_data[81:66]);
                check_field("end_of_file", oldest_report.eof, m_last);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        reset_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // header count of zero ends at the twelfth byte, later bytes ignored
        emit_file(32'd4);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // negative header size
        emit_file(32'h8000_0000);
        // data ahead of fmt is skipped; stereo16 at full-scale rate, odd tail
        add_chunk(TAG_DATA, 3);
        add_fmt(16, FMT_TAG_PCM, 16'd2, 32'hFFFF_FFFF, 16'd16);
        body_fill = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAB};
        add_chunk(TAG_DATA, 5);
        emit_file(file_body.size() + 4);
        // mono8, zero rate, end lands on a sample
        add_fmt(16, FMT_TAG_PCM, 16'd1, 32'd0, 16'd8);
        body_fill = '{8'h00, 8'hFF};
        add_chunk(TAG_DATA, 2);
        emit_file(file_body.size() + 4);
        // short fmt gives no report; empty data chunk closes the file
        add_fmt(6, FMT_TAG_PCM, 16'd2, 32'h0001_F400, 16'd16);
        add_chunk(ID_LIST, 1);
        add_chunk(TAG_DATA, 0);
        emit_file(file_body.size() + 4);
        // non-pcm tag with all-ones fields, data skipped
        add_fmt(18, 16'hFFFF, 16'hFFFF, 32'h1234_5678, 16'hFFFF);
        add_chunk(TAG_DATA, 4);
        emit_file(file_body.size() + 4);
        // largest size: the next start of file cuts this one short
        add_fmt(16, FMT_TAG_PCM, 16'd2, 32'd44100, 16'd8);
        add_chunk(TAG_DATA, 30);
        emit_file(32'h7FFF_FFFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin send_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            while (byte_backlog.size() < PHASE_BYTES) random_file();
            // hold the sender until every report of the phase is in
            wait_drained();
        end

        send_idle_pct = 0;
        sink_stall_pct = 0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wrcp_pkg.sv
hdl/wrcp_core.sv
hdl/wav_riff_chunk_parser_top.sv
hdl/wrcp_checker.sv
verif/wav_riff_chunk_parser_top_tb.sv
